@@ hdl/abs_enc_pkg.sv @@
package abs_enc_pkg;

  localparam int TURN_BITS  = 16;
  localparam int COUNT_BITS = 20;
  localparam int ANGLE_BITS = 20;

  localparam int RAW_W      = 20;
  localparam int RATE_W     = 16;
  localparam int COEF_W     = 16;
  localparam int PP_W       = 7;
  localparam int OFFS_W     = 20;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 2;

  localparam int POS_W = 36;
  localparam int REL_W = 37;
  localparam int VEL_W = 36;

  localparam int DIFF_W    = COUNT_BITS + 2;
  localparam int FRAC_BITS = 16;
  localparam int MCAND_W   = 37;
  localparam int MPLIER_W  = COEF_W + 1;
  localparam int ACC_W     = MCAND_W + MPLIER_W;
  localparam int CNT_W     = $clog2(MPLIER_W + 1);

  localparam int ANG_SHL = (ANGLE_BITS >= COUNT_BITS) ? ANGLE_BITS - COUNT_BITS : 0;
  localparam int ANG_SHR = (COUNT_BITS > ANGLE_BITS) ? COUNT_BITS - ANGLE_BITS : 0;

  localparam logic [RATE_W-1:0] RATE_RST = RATE_W'(10000);
  localparam logic [COEF_W-1:0] COEF_RST = '0;
  localparam logic [PP_W-1:0]   PP_RST   = PP_W'(4);
  localparam logic [OFFS_W-1:0] OFFS_RST = OFFS_W'(528862);

  localparam logic [MPLIER_W-1:0] COEF_ONE = MPLIER_W'(1) << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_RATE,
    CFG_FILTER_COEF,
    CFG_POLE_PAIRS,
    CFG_ELEC_OFFSET
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_VEL,
    ST_FILT_NEW,
    ST_FILT_OLD,
    ST_ANGLE,
    ST_OUT
  } seq_state_t;

  typedef struct packed {
    logic             start;
    logic             clear;
    logic [CNT_W-1:0] steps;
  } mac_ctrl_t;

  // Scale a single-turn count to ANGLE_BITS counts per turn.
  function automatic logic [ANGLE_BITS-1:0] to_angle(input logic [COUNT_BITS-1:0] raw);
    logic [ANGLE_BITS-1:0] scaled;
    scaled = ANGLE_BITS'(raw >> ANG_SHR);
    return scaled << ANG_SHL;
  endfunction

endpackage

@@ hdl/abs_encoder_multiturn_velocity.sv @@
// Channel  Direction  Handshake            Payload
// cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
// in       in         in_valid/in_ready    cmd, raw_position
// out      out        out_valid/out_ready  multi_turn_count, relative_position,
//                                          raw_velocity, filtered_velocity,
//                                          electrical_angle
// A primed position sample makes four passes through the shared shift-add multiplier
// (16, 17, 16 and 7 steps); the first sample after reset makes only the last pass.
// A set-home transaction completes in the accepting cycle and gives no result.
// in_ready is high only while the sequencer is idle; a finished result waits in the
// output register, and the next sample finishes only once that register is free.
// rst is synchronous; cfg_ready is always high.
module abs_encoder_multiturn_velocity (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [abs_enc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [abs_enc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic                                     cmd,
  input  logic [abs_enc_pkg::RAW_W-1:0]            raw_position,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [abs_enc_pkg::POS_W-1:0]     multi_turn_count,
  output logic signed [abs_enc_pkg::REL_W-1:0]     relative_position,
  output logic signed [abs_enc_pkg::VEL_W-1:0]     raw_velocity,
  output logic signed [abs_enc_pkg::VEL_W-1:0]     filtered_velocity,
  output logic        [abs_enc_pkg::ANGLE_BITS-1:0] electrical_angle
);

  localparam int DW = abs_enc_pkg::DIFF_W;
  localparam int AW = abs_enc_pkg::ACC_W;
  localparam int VW = abs_enc_pkg::VEL_W;
  localparam logic signed [DW-1:0] HALF_TURN = DW'(1) <<< (abs_enc_pkg::COUNT_BITS - 1);
  localparam logic signed [DW-1:0] FULL_TURN = DW'(1) <<< abs_enc_pkg::COUNT_BITS;
  localparam logic signed [AW-1:0] VEL_MAX_A = {{(AW - VW + 1){1'b0}}, {(VW - 1){1'b1}}};
  localparam logic signed [AW-1:0] VEL_MIN_A = {{(AW - VW + 1){1'b1}}, {(VW - 1){1'b0}}};

  // configuration
  logic [abs_enc_pkg::RATE_W-1:0] sample_rate;
  logic [abs_enc_pkg::COEF_W-1:0] filter_coef;
  logic [abs_enc_pkg::PP_W-1:0]   pole_pairs;
  logic [abs_enc_pkg::OFFS_W-1:0] elec_offset;

  // tracking state
  abs_enc_pkg::seq_state_t state, state_next;
  logic [abs_enc_pkg::COUNT_BITS-1:0] cur_raw;
  logic [abs_enc_pkg::COUNT_BITS-1:0] prev_raw;
  logic [abs_enc_pkg::COUNT_BITS-1:0] home_count;
  logic [abs_enc_pkg::TURN_BITS-1:0]  turn_counter;
  logic signed [VW-1:0]               vel_raw;
  logic signed [VW-1:0]               vel_mem;
  logic                               primed;

  // shared multiplier
  abs_enc_pkg::mac_ctrl_t                        mac_ctrl;
  logic signed [abs_enc_pkg::MCAND_W-1:0]        mac_mcand;
  logic        [abs_enc_pkg::MPLIER_W-1:0]       mac_mplier;
  logic signed [AW-1:0]                          mac_acc;
  logic                                          mac_done;

  logic                                 in_fire;
  logic                                 out_free;
  logic signed [DW-1:0]                 diff_step;
  logic signed [DW-1:0]                 diff_fix;
  logic                                 wrap_down;
  logic                                 wrap_up;
  logic signed [VW-1:0]                 vel_sat;
  logic signed [AW-1:0]                 acc_shifted;
  logic signed [VW-1:0]                 filt;
  logic [abs_enc_pkg::ANGLE_BITS-1:0]   angle;
  logic [abs_enc_pkg::ANGLE_BITS-1:0]   angle_counts;
  logic [abs_enc_pkg::POS_W-1:0]        multi;
  logic [abs_enc_pkg::REL_W-1:0]        rel;

  abs_enc_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .mcand  (mac_mcand),
    .mplier (mac_mplier),
    .acc    (mac_acc),
    .done   (mac_done)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == abs_enc_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // unwrap: a step beyond half a turn either way is a turn wrap
  assign diff_step = DW'(cur_raw) - DW'(prev_raw);
  assign wrap_down = diff_step > HALF_TURN;
  assign wrap_up   = diff_step < -HALF_TURN;
  always_comb begin
    diff_fix = diff_step;
    if (wrap_down) begin
      diff_fix = diff_step - FULL_TURN;
    end else if (wrap_up) begin
      diff_fix = diff_step + FULL_TURN;
    end
  end

  always_comb begin
    if (mac_acc > VEL_MAX_A) begin
      vel_sat = VEL_MAX_A[VW-1:0];
    end else if (mac_acc < VEL_MIN_A) begin
      vel_sat = VEL_MIN_A[VW-1:0];
    end else begin
      vel_sat = mac_acc[VW-1:0];
    end
  end

  assign acc_shifted  = mac_acc >>> abs_enc_pkg::FRAC_BITS;
  assign filt         = acc_shifted[VW-1:0];
  assign angle_counts = abs_enc_pkg::to_angle(cur_raw);
  assign angle        = abs_enc_pkg::ANGLE_BITS'(0) - mac_acc[abs_enc_pkg::ANGLE_BITS-1:0]
                        - abs_enc_pkg::ANGLE_BITS'(elec_offset);
  assign multi = (abs_enc_pkg::POS_W'(signed'(turn_counter)) << abs_enc_pkg::COUNT_BITS)
                 + abs_enc_pkg::POS_W'(cur_raw);
  assign rel   = abs_enc_pkg::REL_W'(signed'(multi)) - abs_enc_pkg::REL_W'(home_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= abs_enc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    mac_ctrl.start = 1'b0;
    mac_ctrl.clear = 1'b0;
    mac_ctrl.steps = abs_enc_pkg::CNT_W'(abs_enc_pkg::PP_W);
    mac_mcand      = signed'(abs_enc_pkg::MCAND_W'(angle_counts));
    mac_mplier     = abs_enc_pkg::MPLIER_W'(pole_pairs);
    case (state)
      abs_enc_pkg::ST_IDLE: begin
        if (in_fire && !cmd) begin
          state_next = abs_enc_pkg::ST_DIFF;
        end
      end
      abs_enc_pkg::ST_DIFF: begin
        mac_ctrl.start = 1'b1;
        mac_ctrl.clear = 1'b1;
        if (primed) begin
          mac_ctrl.steps = abs_enc_pkg::CNT_W'(abs_enc_pkg::RATE_W);
          mac_mcand      = abs_enc_pkg::MCAND_W'(diff_fix);
          mac_mplier     = abs_enc_pkg::MPLIER_W'(sample_rate);
          state_next     = abs_enc_pkg::ST_VEL;
        end else begin
          state_next = abs_enc_pkg::ST_ANGLE;
        end
      end
      abs_enc_pkg::ST_VEL: begin
        // new velocity weighted by one minus the coefficient
        mac_ctrl.steps = abs_enc_pkg::CNT_W'(abs_enc_pkg::MPLIER_W);
        mac_mcand      = abs_enc_pkg::MCAND_W'(vel_sat);
        mac_mplier     = abs_enc_pkg::COEF_ONE - abs_enc_pkg::MPLIER_W'(filter_coef);
        if (mac_done) begin
          mac_ctrl.start = 1'b1;
          mac_ctrl.clear = 1'b1;
          state_next     = abs_enc_pkg::ST_FILT_NEW;
        end
      end
      abs_enc_pkg::ST_FILT_NEW: begin
        // accumulate the previous filtered velocity on top
        mac_ctrl.steps = abs_enc_pkg::CNT_W'(abs_enc_pkg::COEF_W);
        mac_mcand      = abs_enc_pkg::MCAND_W'(vel_mem);
        mac_mplier     = abs_enc_pkg::MPLIER_W'(filter_coef);
        if (mac_done) begin
          mac_ctrl.start = 1'b1;
          state_next     = abs_enc_pkg::ST_FILT_OLD;
        end
      end
      abs_enc_pkg::ST_FILT_OLD: begin
        if (mac_done) begin
          mac_ctrl.start = 1'b1;
          mac_ctrl.clear = 1'b1;
          state_next     = abs_enc_pkg::ST_ANGLE;
        end
      end
      abs_enc_pkg::ST_ANGLE: begin
        if (mac_done) begin
          state_next = abs_enc_pkg::ST_OUT;
        end
      end
      abs_enc_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = abs_enc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = abs_enc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= abs_enc_pkg::RATE_RST;
      filter_coef <= abs_enc_pkg::COEF_RST;
      pole_pairs  <= abs_enc_pkg::PP_RST;
      elec_offset <= abs_enc_pkg::OFFS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (abs_enc_pkg::cfg_reg_t'(cfg_index))
        abs_enc_pkg::CFG_SAMPLE_RATE: sample_rate <= abs_enc_pkg::RATE_W'(cfg_data);
        abs_enc_pkg::CFG_FILTER_COEF: filter_coef <= abs_enc_pkg::COEF_W'(cfg_data);
        abs_enc_pkg::CFG_POLE_PAIRS:  pole_pairs  <= abs_enc_pkg::PP_W'(cfg_data);
        abs_enc_pkg::CFG_ELEC_OFFSET: elec_offset <= abs_enc_pkg::OFFS_W'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_raw     <= '0;
      home_count   <= '0;
      turn_counter <= '0;
      vel_mem      <= '0;
      primed       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (in_fire) begin
        if (cmd) begin
          turn_counter <= '0;
          home_count   <= prev_raw;
        end
      end
      if (state == abs_enc_pkg::ST_DIFF) begin
        prev_raw <= cur_raw;
        primed   <= 1'b1;
        if (!primed) begin
          vel_mem <= '0;
        end else if (wrap_down) begin
          turn_counter <= turn_counter - abs_enc_pkg::TURN_BITS'(1);
        end else if (wrap_up) begin
          turn_counter <= turn_counter + abs_enc_pkg::TURN_BITS'(1);
        end
      end
      if (state == abs_enc_pkg::ST_FILT_OLD && mac_done) begin
        vel_mem <= filt;
      end
      if (state == abs_enc_pkg::ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !cmd) begin
      cur_raw <= abs_enc_pkg::COUNT_BITS'(raw_position);
    end
    if (state == abs_enc_pkg::ST_DIFF && !primed) begin
      vel_raw <= '0;
    end
    if (state == abs_enc_pkg::ST_VEL && mac_done) begin
      vel_raw <= vel_sat;
    end
    if (state == abs_enc_pkg::ST_OUT && out_free) begin
      multi_turn_count  <= signed'(multi);
      relative_position <= signed'(rel);
      raw_velocity      <= vel_raw;
      filtered_velocity <= vel_mem;
      electrical_angle  <= angle;
    end
  end

endmodule

@@ hdl/abs_enc_mac.sv @@
module abs_enc_mac (
  input  logic                                      clk,
  input  logic                                      rst,
  input  abs_enc_pkg::mac_ctrl_t                    ctrl,
  input  logic signed [abs_enc_pkg::MCAND_W-1:0]    mcand,
  input  logic        [abs_enc_pkg::MPLIER_W-1:0]   mplier,
  output logic signed [abs_enc_pkg::ACC_W-1:0]      acc,
  output logic                                      done
);

  logic signed [abs_enc_pkg::ACC_W-1:0]    mc;
  logic        [abs_enc_pkg::MPLIER_W-1:0] mp;
  logic        [abs_enc_pkg::CNT_W-1:0]    cnt;
  logic                                    busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= ctrl.steps;
      end else if (busy) begin
        cnt <= cnt - abs_enc_pkg::CNT_W'(1);
        if (cnt == abs_enc_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift-add: one multiplier bit per cycle, LSB first.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      mc <= abs_enc_pkg::ACC_W'(mcand);
      mp <= mplier;
      if (ctrl.clear) begin
        acc <= '0;
      end
    end else if (busy) begin
      if (mp[0]) begin
        acc <= acc + mc;
      end
      mc <= mc <<< 1;
      mp <= mp >> 1;
    end
  end

endmodule

@@ verif/abs_enc_checker.sv @@
package abs_enc_tb_pkg;

  typedef enum logic {
    CMD_SAMPLE,
    CMD_HOME
  } enc_cmd_t;

endpackage

module abs_enc_checker
  import abs_enc_pkg::*, abs_enc_tb_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         cmd,
  input  logic [RAW_W-1:0]             raw_position,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic signed [POS_W-1:0]      multi_turn_count,
  input  logic signed [REL_W-1:0]      relative_position,
  input  logic signed [VEL_W-1:0]      raw_velocity,
  input  logic signed [VEL_W-1:0]      filtered_velocity,
  input  logic        [ANGLE_BITS-1:0] electrical_angle,
  output int                           mismatches,
  output int                           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint VEL_HI = (longint'(1) <<< (VEL_W - 1)) - 1;
  localparam longint VEL_LO = -VEL_HI - 1;
  localparam longint HALF   = longint'(1) <<< (COUNT_BITS - 1);
  localparam longint SPAN   = longint'(1) <<< COUNT_BITS;

  typedef struct {
    logic signed [POS_W-1:0] multi_turn;
    logic signed [REL_W-1:0] rel_pos;
    logic signed [VEL_W-1:0] raw_vel;
    logic signed [VEL_W-1:0] filt_vel;
    logic [ANGLE_BITS-1:0]   angle;
  } track_t;

  logic [RATE_W-1:0]     rate_q;
  logic [COEF_W-1:0]     coef_q;
  logic [PP_W-1:0]       poles_q;
  logic [OFFS_W-1:0]     offset_q;

  logic [COUNT_BITS-1:0] last_raw;
  logic [TURN_BITS-1:0]  turns;
  logic [COUNT_BITS-1:0] home_raw;
  longint                vel_state;
  bit                    primed;

  track_t                sample_reports[$];
  track_t                want;

  function automatic track_t track_sample(input logic [COUNT_BITS-1:0] raw);
    longint step;
    longint rawv;
    longint filt;
    longint multi;
    track_t r;
    rawv = 0;
    filt = 0;
    if (primed) begin
      step = longint'(raw) - longint'(last_raw);
      // a step beyond half a turn is a wrap; exactly half is not
      if (step > HALF) begin
        turns = turns - 1'b1;
        step  = step - SPAN;
      end else if (step < -HALF) begin
        turns = turns + 1'b1;
        step  = step + SPAN;
      end
      rawv = step * longint'(rate_q);
      if (rawv > VEL_HI) rawv = VEL_HI;
      if (rawv < VEL_LO) rawv = VEL_LO;
      // arithmetic shift of a signed value floors toward minus infinity
      filt = (rawv * (longint'(1) <<< FRAC_BITS) - rawv * longint'(coef_q)
              + vel_state * longint'(coef_q)) >>> FRAC_BITS;
    end
    vel_state = filt;
    last_raw  = raw;
    primed    = 1'b1;

    multi      = longint'($signed(turns)) * SPAN + longint'(raw);
    r.multi_turn = POS_W'(multi);
    r.rel_pos    = REL_W'(longint'(r.multi_turn) - longint'(home_raw));
    r.raw_vel    = VEL_W'(rawv);
    r.filt_vel   = VEL_W'(filt);
    r.angle      = ANGLE_BITS'(-(((longint'(raw) >> ANG_SHR) << ANG_SHL)
                                 * longint'(poles_q)) - longint'(offset_q));
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] exp_val,
                             input logic signed [63:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rate_q    = RATE_RST;
      coef_q    = COEF_RST;
      poles_q   = PP_RST;
      offset_q  = OFFS_RST;
      last_raw  = '0;
      turns     = '0;
      home_raw  = '0;
      vel_state = 0;
      primed    = 1'b0;
      sample_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SAMPLE_RATE: rate_q   = cfg_data[RATE_W-1:0];
          CFG_FILTER_COEF: coef_q   = cfg_data[COEF_W-1:0];
          CFG_POLE_PAIRS:  poles_q  = cfg_data[PP_W-1:0];
          CFG_ELEC_OFFSET: offset_q = cfg_data[OFFS_W-1:0];
          default: ;
        endcase
      end
      // retire results before taking the new transaction
      if (out_valid && out_ready) begin
        if (sample_reports.size() == 0) begin
          $error("result with no sample outstanding");
          mismatches++;
        end else begin
          want = sample_reports.pop_front();
          check_field("multi_turn_count", want.multi_turn, multi_turn_count);
          check_field("relative_position", want.rel_pos, relative_position);
          check_field("raw_velocity", want.raw_vel, raw_velocity);
          check_field("filtered_velocity", want.filt_vel, filtered_velocity);
          check_field("electrical_angle", want.angle, electrical_angle);
        end
      end
      if (in_valid && in_ready) begin
        if (cmd == CMD_HOME) begin
          turns    = '0;
          home_raw = last_raw;
        end else begin
          sample_reports.push_back(track_sample(raw_position[COUNT_BITS-1:0]));
        end
      end
    end
    pending = sample_reports.size();
  end

endmodule

@@ verif/tb.sv @@
module tb
  import abs_enc_pkg::*, abs_enc_tb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 80;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 170;
  localparam logic [RAW_W-1:0] HALF_TURN = RAW_W'(1) << (COUNT_BITS - 1);

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     cmd = 1'b0;
  logic [RAW_W-1:0]         raw_position = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [POS_W-1:0]  multi_turn_count;
  logic signed [REL_W-1:0]  relative_position;
  logic signed [VEL_W-1:0]  raw_velocity;
  logic signed [VEL_W-1:0]  filtered_velocity;
  logic [ANGLE_BITS-1:0]    electrical_angle;

  int mismatches;
  int pending;

  int burst_left = 0;
  int max_gap = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int hold_tag = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  logic [RAW_W-1:0] path_pos = '0;

  always #10 clk = ~clk;

  abs_encoder_multiturn_velocity uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .raw_position(raw_position),
    .out_valid(out_valid), .out_ready(out_ready),
    .multi_turn_count(multi_turn_count), .relative_position(relative_position),
    .raw_velocity(raw_velocity), .filtered_velocity(filtered_velocity),
    .electrical_angle(electrical_angle)
  );

  abs_enc_checker u_check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .raw_position(raw_position),
    .out_valid(out_valid), .out_ready(out_ready),
    .multi_turn_count(multi_turn_count), .relative_position(relative_position),
    .raw_velocity(raw_velocity), .filtered_velocity(filtered_velocity),
    .electrical_angle(electrical_angle),
    .mismatches(mismatches), .pending(pending)
  );

  // receiver: short random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_tag) begin
      out_ready <= 1'b0;
      hold_seen <= hold_tag;
      hold_left <= HOLD_CYCLES;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(1, 90);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  task automatic offer(input enc_cmd_t kind, input logic [RAW_W-1:0] pos);
    int gap;
    if (burst_left == 0) begin
      gap = (max_gap == 0) ? 0 : $urandom_range(max_gap);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid     <= 1'b1;
    cmd          <= kind;
    raw_position <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    if (kind == CMD_SAMPLE) path_pos = pos;
  endtask

  // drop valid, drain every outstanding result, then let a home transaction settle
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] rate, coef, poles, offset);
    logic [CFG_DATA_W-1:0] vals [4];
    cfg_reg_t idx;
    vals = '{rate, coef, poles, offset};
    idx = idx.first();
    repeat (idx.num()) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= vals[idx];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      idx = idx.next();
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int count, input int speed_max);
    int speed;
    int pick;
    logic [RAW_W-1:0] pos;
    speed = int'($urandom_range(2 * speed_max)) - speed_max;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        offer(CMD_HOME, RAW_W'($urandom));
      end else if (pick < 18) begin
        offer(CMD_SAMPLE, RAW_W'($urandom));
      end else if (pick < 24) begin
        case ($urandom_range(3))
          0: pos = path_pos + HALF_TURN;
          1: pos = path_pos + HALF_TURN + 1'b1;
          2: pos = path_pos + HALF_TURN - 1'b1;
          default: pos = path_pos - HALF_TURN + 1'b1;
        endcase
        offer(CMD_SAMPLE, pos);
      end else begin
        if ($urandom_range(31) == 0)
          speed = int'($urandom_range(2 * speed_max)) - speed_max;
        pos = RAW_W'(int'(path_pos) + speed + int'($urandom_range(6)) - 3);
        offer(CMD_SAMPLE, pos);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: home before any sample, priming, wraps and exact half turns
    max_gap   = 12;
    stall_pct = 3;
    offer(CMD_HOME, '1);
    offer(CMD_SAMPLE, '1);
    offer(CMD_SAMPLE, '0);
    offer(CMD_SAMPLE, HALF_TURN);
    offer(CMD_SAMPLE, '0);
    offer(CMD_SAMPLE, HALF_TURN + 1'b1);
    offer(CMD_SAMPLE, '0);
    offer(CMD_SAMPLE, HALF_TURN - 1'b1);
    offer(CMD_SAMPLE, RAW_W'(20'h12345));
    offer(CMD_HOME, RAW_W'(20'hAAAAA));
    offer(CMD_SAMPLE, RAW_W'(20'h12340));
    offer(CMD_SAMPLE, RAW_W'(20'h55555));
    offer(CMD_SAMPLE, RAW_W'(20'hAAAAA));
    offer(CMD_SAMPLE, RAW_W'(20'hAAAAA));

    for (int ph = 0; ph < PHASES; ph++) begin
      max_gap   = (ph == 1) ? 0 : $urandom_range(5, 80);
      stall_pct = (ph == 1) ? 0 : $urandom_range(1, 6);
      if (ph != 0) quiesce();
      case (ph)
        0: ;
        1: begin
          program_regs(CFG_DATA_W'(65535), CFG_DATA_W'(65535), CFG_DATA_W'(64), '1);
          offer(CMD_SAMPLE, '0);
          offer(CMD_SAMPLE, HALF_TURN);
          offer(CMD_SAMPLE, '0);
          offer(CMD_SAMPLE, HALF_TURN + 1'b1);
          // stall the output while input keeps coming, so the block backs up
          hold_tag <= hold_tag + 1;
        end
        2: program_regs(CFG_DATA_W'(1), '0, CFG_DATA_W'(1), '0);
        3: program_regs('0, CFG_DATA_W'(32768), '0, CFG_DATA_W'(12345));
        4: program_regs(CFG_DATA_W'(65535), '0, CFG_DATA_W'(127), CFG_DATA_W'($urandom));
        default: program_regs(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                              CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
      endcase
      run_phase(PHASE_ITEMS, (ph == 1) ? 400000 : $urandom_range(8, 60000));
    end

    quiesce();
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

@@ abs_encoder_multiturn_velocity.f @@
hdl/abs_enc_pkg.sv
hdl/abs_enc_mac.sv
hdl/abs_encoder_multiturn_velocity.sv
verif/abs_enc_checker.sv
verif/tb.sv
